// ----- rtl/mse_pkg.sv -----
package mse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PARAM_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int PA_W  = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int DIV_W = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    CMD_NOP         = 4'd0,
    CMD_PUSH        = 4'd1,
    CMD_PUSH_PARAM  = 4'd2,
    CMD_ADD         = 4'd3,
    CMD_SUB         = 4'd4,
    CMD_MUL         = 4'd5,
    CMD_DIV         = 4'd6,
    CMD_PRIMITIVE   = 4'd7,
    CMD_WRITE_PARAM = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand;
    logic [7:0]         index;
    logic               begin_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         prim_code;
    logic [4:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [5:0]         entry_count;
    logic               last;
    logic               known_prim;
    logic               all_known;
    logic               fault;
  } out_item_t;

  // Instruction as classified by the front part.
  typedef struct packed {
    in_item_t item;
    logic     known;
    logic     param_ok;
  } op_t;

endpackage

// ----- rtl/mse_ram.sv -----
module mse_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mse_div.sv -----
module mse_div
  import mse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   mag_o,
  output logic               neg_o
);

  localparam int CntW = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic             neg_q, neg_d;
  logic [32:0]      rem_s;
  logic [31:0]      num_mag, den_mag;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign rem_s   = {rem_q, dq_q[DIV_W-1]};

  // Restoring division, one quotient bit per cycle on magnitudes.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dq_d   = dq_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_mag;
      dq_d   = {num_mag, {FRAC_BITS{1'b0}}};
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (rem_s >= {1'b0, den_q}) begin
        rem_d = 32'(rem_s - {1'b0, den_q});
        dq_d  = {dq_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_s[31:0];
        dq_d  = {dq_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dq_q  <= dq_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign mag_o  = dq_q;
  assign neg_o  = neg_q;

endmodule

// ----- rtl/mse_front.sv -----
module mse_front
  import mse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     op_valid_o,
  input  logic     op_pop_i,
  output op_t      op_o
);

  op_t        ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  op_t        cls;

  function automatic logic prim_known(input logic [7:0] c);
    return c == 8'd1 || c == 8'd2 || c == 8'd4 || c == 8'd5 || c == 8'd6 ||
           c == 8'd7 || c == 8'd20 || c == 8'd21 || c == 8'd22;
  endfunction

  always_comb begin
    cls.item     = in_item_i;
    cls.known    = prim_known(in_item_i.index);
    cls.param_ok = (in_item_i.index >= 8'd1) &&
                   ({1'b0, in_item_i.index} <= 9'(PARAM_DEPTH));
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (op_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, op_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

// ----- rtl/mse_back.sv -----
module mse_back
  import mse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  output logic      op_pop_o,
  input  op_t       op_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV, S_WB, S_PR_RD, S_PR_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    s.ovf = 1'b1;
    if (v > 64'sd2147483647) begin
      s.val = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      s.val = 32'sh80000000;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  state_e             state_q, state_d;
  logic [SP_W-1:0]    sp_q, sp_d, sp_eff;
  logic               ak_q, ak_d, ak_eff;
  logic               flt_q, flt_d, flt_eff;
  op_t                cur_q, cur_d;
  logic signed [31:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic signed [63:0] prod_q, prod_d;
  logic [SA_W-1:0]    i_q, i_d;
  logic [SP_W-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic signed [31:0] param_q [PARAM_DEPTH];
  logic               pw_en;
  logic [PA_W-1:0]    pw_addr;

  logic               we;
  logic [SA_W-1:0]    waddr, raddr;
  logic [31:0]        wdata, rdata;

  logic               div_start, div_done, div_neg;
  logic [DIV_W-1:0]   div_mag;
  logic signed [63:0] div_val;
  sat_t               sat;
  logic               slot_free, last;

  mse_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (a_q),
    .den_i   (b_q),
    .done_o  (div_done),
    .mag_o   (div_mag),
    .neg_o   (div_neg)
  );

  assign div_val   = div_neg ? -$signed(64'(div_mag)) : $signed(64'(div_mag));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last      = ({1'b0, i_q} + 1'b1) >= cnt_q;
  assign pw_addr   = PA_W'(op_i.item.index - 8'd1);

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    ak_d        = ak_q;
    flt_d       = flt_q;
    cur_d       = cur_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    prod_d      = prod_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op_pop_o    = 1'b0;
    pw_en       = 1'b0;
    we          = 1'b0;
    waddr       = SA_W'(sp_q);
    wdata       = 32'(op_i.item.operand);
    raddr       = SA_W'(sp_q - 1'b1);
    div_start   = 1'b0;
    sat         = sat64(64'sd0);
    sp_eff      = op_i.item.begin_req ? '0 : sp_q;
    ak_eff      = op_i.item.begin_req ? 1'b1 : ak_q;
    flt_eff     = op_i.item.begin_req ? 1'b0 : flt_q;

    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          cur_d    = op_i;
          sp_d     = sp_eff;
          ak_d     = ak_eff;
          flt_d    = flt_eff;
          waddr    = SA_W'(sp_eff);
          raddr    = SA_W'(sp_eff - 1'b1);
          case (op_i.item.cmd)
            CMD_PUSH, CMD_PUSH_PARAM: begin
              if (op_i.item.cmd == CMD_PUSH_PARAM) begin
                wdata = op_i.param_ok ? 32'(param_q[pw_addr]) : 32'd0;
              end
              if (sp_eff >= SP_W'(STACK_DEPTH)) begin
                flt_d = 1'b1;
              end else begin
                we   = 1'b1;
                sp_d = sp_eff + 1'b1;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (sp_eff < SP_W'(2)) begin
                flt_d = 1'b1;
              end else begin
                state_d = S_RD1;
              end
            end
            CMD_WRITE_PARAM: begin
              pw_en = op_i.param_ok;
            end
            CMD_PRIMITIVE: begin
              if (!op_i.known) begin
                ak_d = 1'b0;
              end
              cnt_d   = sp_eff;
              i_d     = '0;
              raddr   = '0;
              state_d = (sp_eff == '0) ? S_PR_OUT : S_PR_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD1: begin
        b_d     = rdata;
        raddr   = SA_W'(sp_q - SP_W'(2));
        state_d = S_RD2;
      end
      S_RD2: begin
        a_d     = rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WB;
        case (cur_q.item.cmd)
          CMD_ADD: begin
            sat   = sat64(64'(a_q) + 64'(b_q));
            res_d = sat.val;
            flt_d = flt_q | sat.ovf;
          end
          CMD_SUB: begin
            sat   = sat64(64'(a_q) - 64'(b_q));
            res_d = sat.val;
            flt_d = flt_q | sat.ovf;
          end
          CMD_MUL: begin
            prod_d  = 64'(a_q) * 64'(b_q);
            state_d = S_MUL;
          end
          default: begin
            if (b_q == 32'sd0) begin
              flt_d = 1'b1;
              if (a_q > 32'sd0) begin
                res_d = 32'sh7FFFFFFF;
              end else if (a_q < 32'sd0) begin
                res_d = 32'sh80000000;
              end else begin
                res_d = 32'sd0;
              end
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        sat     = sat64((prod_q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        res_d   = sat.val;
        flt_d   = flt_q | sat.ovf;
        state_d = S_WB;
      end
      S_DIV: begin
        if (div_done) begin
          sat     = sat64(div_val);
          res_d   = sat.val;
          flt_d   = flt_q | sat.ovf;
          state_d = S_WB;
        end
      end
      S_WB: begin
        we      = 1'b1;
        waddr   = SA_W'(sp_q - SP_W'(2));
        wdata   = 32'(res_q);
        sp_d    = sp_q - 1'b1;
        state_d = S_IDLE;
      end
      S_PR_RD: begin
        raddr   = i_q;
        state_d = S_PR_OUT;
      end
      S_PR_OUT: begin
        raddr = i_q;
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.prim_code   = cur_q.item.index;
          out_d.entry_index = 5'(i_q);
          out_d.entry_value = (cnt_q == '0) ? 32'sd0 : $signed(rdata);
          out_d.entry_count = 6'(cnt_q);
          out_d.last        = last;
          out_d.known_prim  = cur_q.known;
          out_d.all_known   = ak_q;
          out_d.fault       = flt_q;
          if (last) begin
            sp_d    = '0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_PR_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      ak_q        <= 1'b1;
      flt_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < PARAM_DEPTH; k++) begin
        param_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      ak_q        <= ak_d;
      flt_q       <= flt_d;
      out_valid_q <= out_valid_d;
      if (pw_en) begin
        param_q[pw_addr] <= op_i.item.operand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    i_q    <= i_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> state_q == S_IDLE)
    else $error("queue popped while busy");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PR_OUT && slot_free && last) |=> sp_q == '0)
    else $error("stack not emptied after primitive run");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

endmodule

// ----- rtl/macro_stack_evaluator_core.sv -----
// Stack machine for compiled aperture-macro programs, signed Q16.16.
// Input channel (in_valid_i / in_stall_o / in_item_i): one instruction per
// item; an item is taken at a clock edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i / out_item_o): a primitive
// instruction yields one record per stack entry, bottom first, with last
// set on the final record; an empty stack gives a single zero record.
// A two-entry queue parts the front from the execution unit, so up to two
// items are taken while the back part is busy or the receiver stalls.
// In the execution unit push, write_param and nop finish in S_IDLE; add
// and sub pass S_RD1, S_RD2, S_EXEC and S_WB; mul adds S_MUL to round and
// saturate; div waits in S_DIV on the bit-serial divider (FRAC_BITS + 32
// quotient bits) but skips it on a zero divisor; a primitive reads each
// entry from the registered stack memory in S_PR_RD, emits it in S_PR_OUT.
// A stalled receiver holds the output register and the run pauses.
// Reset empties the stack, clears the parameter table and the fault flag,
// and sets the all-known flag; no clearing pass is needed.
module macro_stack_evaluator_core
  import mse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic op_valid, op_pop;
  op_t  op;

  mse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop),
    .op_o       (op)
  );

  mse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_pop_o    (op_pop),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
